FILE: rtl/first_occurrence_filter_defines.svh
// Assertion macros shared by the checker of the first-occurrence filter.
`ifndef FIRST_OCCURRENCE_FILTER_DEFINES_SVH
`define FIRST_OCCURRENCE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define FOOF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FOOF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that also runs during reset.
`define FOOF_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/foof_pkg.sv
package foof_pkg;

  // Width of one sequence element.
  localparam int unsigned ValueW = 32;

  // Probe that travels down the cell chain, one cell per cycle while the chain advances.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     first;   // Clear the table as the probe passes.
    logic                     hit;     // Value matched a live entry upstream.
    logic                     stored;  // Value was written into an upstream cell.
  } probe_t;

endpackage

FILE: rtl/foof_stream_if.sv
// Input channel: one sequence element per transaction.
interface foof_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [foof_pkg::ValueW-1:0]  value;
  logic                                first;

  modport source (output valid, output value, output first, input ready);
  modport sink   (input valid, input value, input first, output ready);
endinterface

// Result channel: one kept element per transaction.
interface foof_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [foof_pkg::ValueW-1:0]  kept_value;
  logic                                overflow;

  modport source (output valid, output kept_value, output overflow, input ready);
  modport sink   (input valid, input kept_value, input overflow, output ready);
endinterface

FILE: rtl/foof_cell.sv
// One table entry of the chain. It compares the passing probe against its
// entry, takes the value if it is the first free cell the probe reaches,
// and hands the probe on to the next cell.
module foof_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic            probe_vld_i,
  input  foof_pkg::probe_t probe_i,
  output logic            probe_vld_o,
  output foof_pkg::probe_t probe_o
);

  logic                               fill_r, fill_nxt;
  logic signed [foof_pkg::ValueW-1:0] entry_r, entry_nxt;
  logic                               probe_vld_r;
  foof_pkg::probe_t                   probe_r, probe_nxt;
  logic                               live;
  logic                               match;
  logic                               take;

  // Compare, claim and forward.
  always_comb begin
    live      = fill_r && !probe_i.first;
    match     = live && (entry_r == probe_i.value);
    take      = !probe_i.hit && !probe_i.stored && !live;
    fill_nxt  = fill_r;
    entry_nxt = entry_r;
    probe_nxt = probe_i;
    probe_nxt.hit    = probe_i.hit || match;
    probe_nxt.stored = probe_i.stored || take;
    if (probe_vld_i) begin
      fill_nxt = live || take;
      if (take) begin
        entry_nxt = probe_i.value;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 1'b0;
      probe_vld_r <= 1'b0;
    end else if (advance) begin
      fill_r      <= fill_nxt;
      probe_vld_r <= probe_vld_i;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    if (advance) begin
      entry_r <= entry_nxt;
      probe_r <= probe_nxt;
    end
  end

  assign probe_vld_o = probe_vld_r;
  assign probe_o     = probe_r;

endmodule

FILE: rtl/first_occurrence_filter.sv
// Channel   Modport  Transaction
// in_ch     sink     value (signed 32), first (start of a new sequence)
// out_ch    source   kept_value (signed 32), overflow (table full, not stored)
//
// Each accepted transaction moves down the SEEN_DEPTH-cell chain, one cell per
// cycle unless stalled, then to the result register; duplicates give none.
// A new transaction can be accepted every cycle while the chain moves.
// The whole chain holds only when its last cell carries a result and the
// result register is still full and not taken.
// Reset is synchronous and active low; it empties the table and the chain
// with no clearing pass.
module first_occurrence_filter #(
  parameter int unsigned SEEN_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  foof_in_if.sink     in_ch,
  foof_out_if.source  out_ch
);

  logic             probe_vld [SEEN_DEPTH+1];
  foof_pkg::probe_t probe     [SEEN_DEPTH+1];
  logic             advance;
  logic             tail_result;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [foof_pkg::ValueW-1:0] out_value_r, out_value_nxt;
  logic                               out_ovf_r, out_ovf_nxt;

  // The chain moves unless a finished result would overwrite a waiting one.
  assign tail_result = probe_vld[SEEN_DEPTH] && !probe[SEEN_DEPTH].hit;
  assign advance     = !(tail_result && out_valid_r && !out_ch.ready);
  assign in_ch.ready = advance;

  // Fresh probe enters the first cell, with no hit and nothing stored yet.
  assign probe_vld[0] = in_ch.valid && advance;
  assign probe[0]     = {in_ch.value, in_ch.first, 1'b0, 1'b0};

  // Row of table cells.
  for (genvar i = 0; i < SEEN_DEPTH; i++) begin : g_cell
    foof_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .advance     (advance),
      .probe_vld_i (probe_vld[i]),
      .probe_i     (probe[i]),
      .probe_vld_o (probe_vld[i+1]),
      .probe_o     (probe[i+1])
    );
  end

  // Result register: a probe that left the chain without a match is kept.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_ovf_nxt   = out_ovf_r;
    if (advance && tail_result) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = probe[SEEN_DEPTH].value;
      out_ovf_nxt   = !probe[SEEN_DEPTH].stored;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kept_value = out_value_r;
  assign out_ch.overflow   = out_ovf_r;

endmodule

FILE: rtl/foof_checker.sv
`include "first_occurrence_filter_defines.svh"

// Port-level checks on the first-occurrence filter.
module foof_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [foof_pkg::ValueW-1:0] out_kept_value,
  input logic                               out_overflow
);

  // A result is offered but not taken in this cycle.
  logic stall;

  assign stall = out_valid && !out_ready;

  // A result that is not taken stays offered.
  `FOOF_ASSERT_NEXT(a_out_hold, stall, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `FOOF_ASSERT_NEXT(a_kept_stable, stall, $stable(out_kept_value), "kept value moved in stall")

  `FOOF_ASSERT_NEXT(a_ovf_stable, stall, $stable(out_overflow), "overflow moved in stall")

  // With no result waiting, the input side is never held off.
  `FOOF_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with no result")

  // The cycle after reset shows no result.
  `FOOF_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n), !out_valid, "result offered after reset")

endmodule

bind first_occurrence_filter foof_checker u_foof_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kept_value (out_ch.kept_value),
  .out_overflow   (out_ch.overflow)
);
